### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms for the detection threshold top-k block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define DTK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The condition must never be true at a clock edge out of reset.
`define DTK_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### design/dtk_pkg.sv
// ---------------------------------------------------------------------------
// dtk_pkg
// Types, register map and sizing constants of the detection threshold top-k
// block.
// ---------------------------------------------------------------------------
`default_nettype none

package dtk_pkg;

	localparam int MAX_KEEP    = 64;
	localparam int CNT_W       = $clog2(MAX_KEEP + 1);
	localparam int IDX_W       = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [QPTR_W-1:0] qptr_t;
	typedef logic [QPTR_W:0] qlevel_t;
	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_SCORE_THRESHOLD = 3'd0;
	localparam reg_idx_t REG_SCALE_X         = 3'd1;
	localparam reg_idx_t REG_SCALE_Y         = 3'd2;
	localparam reg_idx_t REG_IMAGE_WIDTH     = 3'd3;
	localparam reg_idx_t REG_IMAGE_HEIGHT    = 3'd4;
	localparam reg_idx_t REG_KEEP_LIMIT      = 3'd5;

	localparam logic [15:0] RST_SCORE_THRESHOLD = 16'd16384;
	localparam logic [15:0] RST_SCALE           = 16'd4096;
	localparam logic [15:0] RST_IMAGE_SIZE      = 16'd10240;
	localparam logic [6:0]  RST_KEEP_LIMIT      = 7'd64;

	typedef struct packed {
		logic [15:0] score_threshold;
		logic [15:0] scale_x;
		logic [15:0] scale_y;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [6:0]  keep_limit;
	} cfg_t;

	typedef struct packed {
		logic [15:0]        score;
		logic [7:0]         class_id;
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic signed [15:0] right;
		logic signed [15:0] bottom;
		logic               last_query;
	} in_item_t;

	typedef struct packed {
		logic [15:0] box_x;
		logic [15:0] box_y;
		logic [15:0] box_width;
		logic [15:0] box_height;
		logic [15:0] det_score;
		logic [7:0]  det_class;
		logic        last_result;
		logic        none_found;
	} out_item_t;

	typedef struct packed {
		logic [15:0] score;
		logic [7:0]  class_id;
		logic [15:0] x0;
		logic [15:0] y0;
		logic [15:0] x1;
		logic [15:0] y1;
	} det_t;

	typedef struct packed {
		det_t det;
		logic keep;
		logic last;
	} entry_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_status_t;

endpackage

`default_nettype wire

### design/detection_threshold_topk.sv
// ---------------------------------------------------------------------------
// detection_threshold_topk
// Score threshold and top-k selection of detector queries with box rescale.
// ---------------------------------------------------------------------------
// Queries are taken one per cycle while the front stage is not stalled.
// There each is compared with the threshold and its corners are scaled and
// clamped; kept ones and the last of a frame then pass through a four-entry
// queue to the sorted insertion chain, which places one kept detection per
// cycle while it is not draining. When the last query of a frame reaches the
// chain, the kept list is sent out best first at one result per cycle while
// results are taken (a single none-found result when nothing was kept);
// queries keep arriving into the queue meanwhile until it fills. The result
// port is a single register, so results of a frame that are not taken hold
// up the drain, and with it the queue and then the input.
`default_nettype none

module detection_threshold_topk (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [dtk_pkg::ADDR_W-1:0] paddr,
	input  wire logic [dtk_pkg::DATA_W-1:0] pwdata,
	output logic      [dtk_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	input  wire logic                       push,
	output logic                            full,
	input  wire dtk_pkg::in_item_t          in_item,
	output logic                            empty,
	input  wire logic                       pop,
	output dtk_pkg::out_item_t              out_item
);

	dtk_pkg::cfg_t      cfg;
	dtk_pkg::q_status_t q_status;
	dtk_pkg::entry_t    q_wr_entry;
	dtk_pkg::entry_t    q_head;
	logic               q_push;
	logic               q_pop;

	dtk_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dtk_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.q_status (q_status),
		.q_push   (q_push),
		.q_entry  (q_wr_entry)
	);

	dtk_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_entry),
		.rd_en   (q_pop),
		.rd_data (q_head),
		.status  (q_status)
	);

	dtk_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_status (q_status),
		.head     (q_head),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item)
	);

endmodule

`default_nettype wire

### design/dtk_cfg.sv
// ---------------------------------------------------------------------------
// dtk_cfg
// Configuration register file behind the APB-style port.
// ---------------------------------------------------------------------------
`default_nettype none

module dtk_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [dtk_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [dtk_pkg::DATA_W-1:0]  pwdata,
	output logic      [dtk_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	output dtk_pkg::cfg_t                    cfg
);

	dtk_pkg::cfg_t     cfg_q;
	dtk_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = paddr[dtk_pkg::ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.score_threshold <= dtk_pkg::RST_SCORE_THRESHOLD;
			cfg_q.scale_x         <= dtk_pkg::RST_SCALE;
			cfg_q.scale_y         <= dtk_pkg::RST_SCALE;
			cfg_q.image_width     <= dtk_pkg::RST_IMAGE_SIZE;
			cfg_q.image_height    <= dtk_pkg::RST_IMAGE_SIZE;
			cfg_q.keep_limit      <= dtk_pkg::RST_KEEP_LIMIT;
		end else if (wr_en) begin
			case (idx)
				dtk_pkg::REG_SCORE_THRESHOLD: cfg_q.score_threshold <= pwdata[15:0];
				dtk_pkg::REG_SCALE_X:         cfg_q.scale_x         <= pwdata[15:0];
				dtk_pkg::REG_SCALE_Y:         cfg_q.scale_y         <= pwdata[15:0];
				dtk_pkg::REG_IMAGE_WIDTH:     cfg_q.image_width     <= pwdata[15:0];
				dtk_pkg::REG_IMAGE_HEIGHT:    cfg_q.image_height    <= pwdata[15:0];
				dtk_pkg::REG_KEEP_LIMIT:      cfg_q.keep_limit      <= pwdata[6:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			dtk_pkg::REG_SCORE_THRESHOLD: prdata = {16'd0, cfg_q.score_threshold};
			dtk_pkg::REG_SCALE_X:         prdata = {16'd0, cfg_q.scale_x};
			dtk_pkg::REG_SCALE_Y:         prdata = {16'd0, cfg_q.scale_y};
			dtk_pkg::REG_IMAGE_WIDTH:     prdata = {16'd0, cfg_q.image_width};
			dtk_pkg::REG_IMAGE_HEIGHT:    prdata = {16'd0, cfg_q.image_height};
			dtk_pkg::REG_KEEP_LIMIT:      prdata = {25'd0, cfg_q.keep_limit};
			default:                      prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### design/dtk_front.sv
// ---------------------------------------------------------------------------
// dtk_front
// Accepts queries, applies the score threshold and scales and clamps the
// corners of kept queries before handing them to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module dtk_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dtk_pkg::cfg_t       cfg,
	input  wire logic                push,
	output logic                     full,
	input  wire dtk_pkg::in_item_t   in_item,
	input  wire dtk_pkg::q_status_t  q_status,
	output logic                     q_push,
	output dtk_pkg::entry_t          q_entry
);

	function automatic logic [15:0] scale_clamp(logic signed [15:0] c, logic [15:0] r,
			logic [15:0] b);
		logic signed [33:0] p;
		logic [21:0]        v;
		p = $signed({{18{c[15]}}, c}) * $signed({18'd0, r});
		v = p[33:12];
		if (p[33]) begin
			return 16'd0;
		end else if (v > {6'd0, b}) begin
			return b;
		end else begin
			return v[15:0];
		end
	endfunction

	dtk_pkg::in_item_t item_s1;
	logic              valid_s1;
	logic              keep;
	logic              need_push;
	logic              advance;
	logic              accept;

	assign keep      = item_s1.score >= cfg.score_threshold;
	assign need_push = keep || item_s1.last_query;
	assign advance   = valid_s1 && (!need_push || !q_status.full);
	assign full      = valid_s1 && !advance;
	assign accept    = push && !full;
	assign q_push    = valid_s1 && need_push && !q_status.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

	always_comb begin
		q_entry.det.score    = item_s1.score;
		q_entry.det.class_id = item_s1.class_id;
		q_entry.det.x0       = scale_clamp(item_s1.left, cfg.scale_x, cfg.image_width);
		q_entry.det.y0       = scale_clamp(item_s1.top, cfg.scale_y, cfg.image_height);
		q_entry.det.x1       = scale_clamp(item_s1.right, cfg.scale_x, cfg.image_width);
		q_entry.det.y1       = scale_clamp(item_s1.bottom, cfg.scale_y, cfg.image_height);
		q_entry.keep         = keep;
		q_entry.last         = item_s1.last_query;
	end

endmodule

`default_nettype wire

### design/dtk_queue.sv
// ---------------------------------------------------------------------------
// dtk_queue
// Short first-in first-out queue between the front and the back part.
// ---------------------------------------------------------------------------
`default_nettype none

module dtk_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire dtk_pkg::entry_t wr_data,
	input  wire logic            rd_en,
	output dtk_pkg::entry_t      rd_data,
	output dtk_pkg::q_status_t   status
);

	dtk_pkg::entry_t  mem_q [dtk_pkg::QUEUE_DEPTH];
	dtk_pkg::qptr_t   wr_ptr_q;
	dtk_pkg::qptr_t   rd_ptr_q;
	dtk_pkg::qlevel_t level_q;
	logic             do_wr;
	logic             do_rd;

	assign status.valid = level_q != '0;
	assign status.full  = level_q == dtk_pkg::qlevel_t'(dtk_pkg::QUEUE_DEPTH);
	assign do_wr        = wr_en && !status.full;
	assign do_rd        = rd_en && status.valid;
	assign rd_data      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + dtk_pkg::qptr_t'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + dtk_pkg::qptr_t'(1);
			end
			if (do_wr && !do_rd) begin
				level_q <= level_q + dtk_pkg::qlevel_t'(1);
			end else if (do_rd && !do_wr) begin
				level_q <= level_q - dtk_pkg::qlevel_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

### design/dtk_back.sv
// ---------------------------------------------------------------------------
// dtk_back
// Sorted insertion chain of kept detections, frame drain and result register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dtk_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dtk_pkg::cfg_t      cfg,
	input  wire dtk_pkg::q_status_t q_status,
	input  wire dtk_pkg::entry_t    head,
	output logic                    q_pop,
	output logic                    empty,
	input  wire logic               pop,
	output dtk_pkg::out_item_t      out_item
);

	typedef enum logic [2:0] {
		ST_RUN   = 3'b001,
		ST_DRAIN = 3'b010,
		ST_NONE  = 3'b100
	} back_state_t;

	back_state_t        state_q;
	dtk_pkg::det_t      store_q [dtk_pkg::MAX_KEEP];
	dtk_pkg::cnt_t      count_q;
	dtk_pkg::cnt_t      remain_q;
	dtk_pkg::out_item_t out_q;
	logic               out_valid_q;

	logic [dtk_pkg::MAX_KEEP-1:0] ge;
	dtk_pkg::cnt_t cap;
	dtk_pkg::cnt_t cap_dec;
	dtk_pkg::cnt_t n;
	dtk_pkg::cnt_t cnt_ins;
	dtk_pkg::cnt_t eff;
	logic          drop;
	logic          ins_en;
	logic          shift_en;
	logic          slot_free;
	logic          out_load;
	logic          frame_end;
	dtk_pkg::out_item_t drain_item;
	dtk_pkg::out_item_t none_item;

	always_comb begin
		if (32'(cfg.keep_limit) > dtk_pkg::MAX_KEEP) begin
			cap = dtk_pkg::cnt_t'(dtk_pkg::MAX_KEEP);
		end else begin
			cap = dtk_pkg::cnt_t'(cfg.keep_limit);
		end
		cap_dec = cap - dtk_pkg::cnt_t'(1);
		n       = (count_q < cap) ? count_q : cap;
		for (int i = 0; i < dtk_pkg::MAX_KEEP; i++) begin
			ge[i] = (dtk_pkg::cnt_t'(i) < n) && (store_q[i].score >= head.det.score);
		end
		drop = (cap == '0) || ge[cap_dec[dtk_pkg::IDX_W-1:0]];
		if (drop) begin
			cnt_ins = n;
		end else if (n < cap) begin
			cnt_ins = n + dtk_pkg::cnt_t'(1);
		end else begin
			cnt_ins = cap;
		end
		eff = head.keep ? cnt_ins : n;
	end

	assign slot_free = !out_valid_q || pop;
	assign out_load  = slot_free && ((state_q == ST_DRAIN) || (state_q == ST_NONE));
	assign q_pop     = (state_q == ST_RUN) && q_status.valid;
	assign ins_en    = q_pop && head.keep && !drop;
	assign frame_end = q_pop && head.last;
	assign shift_en  = (state_q == ST_DRAIN) && slot_free;
	assign empty     = !out_valid_q;
	assign out_item  = out_q;

	for (genvar g = 0; g < dtk_pkg::MAX_KEEP; g++) begin : g_entry
		dtk_pkg::det_t ins_val;
		dtk_pkg::det_t shift_val;
		if (g == 0) begin : g_first
			assign ins_val = head.det;
		end else begin : g_rest
			assign ins_val = ge[g-1] ? head.det : store_q[g-1];
		end
		if (g == dtk_pkg::MAX_KEEP - 1) begin : g_tail
			assign shift_val = store_q[g];
		end else begin : g_body
			assign shift_val = store_q[g+1];
		end
		always_ff @(posedge clk) begin
			if (ins_en && !ge[g]) begin
				store_q[g] <= ins_val;
			end else if (shift_en) begin
				store_q[g] <= shift_val;
			end
		end
	end

	always_comb begin
		drain_item.box_x       = store_q[0].x0;
		drain_item.box_y       = store_q[0].y0;
		drain_item.box_width   = (store_q[0].x1 > store_q[0].x0) ?
			store_q[0].x1 - store_q[0].x0 : 16'd0;
		drain_item.box_height  = (store_q[0].y1 > store_q[0].y0) ?
			store_q[0].y1 - store_q[0].y0 : 16'd0;
		drain_item.det_score   = store_q[0].score;
		drain_item.det_class   = store_q[0].class_id;
		drain_item.last_result = remain_q == dtk_pkg::cnt_t'(1);
		drain_item.none_found  = 1'b0;
		none_item              = '0;
		none_item.last_result  = 1'b1;
		none_item.none_found   = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			count_q     <= '0;
			remain_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_RUN: begin
					if (frame_end) begin
						count_q  <= '0;
						remain_q <= eff;
						state_q  <= (eff == '0) ? ST_NONE : ST_DRAIN;
					end else if (q_pop && head.keep) begin
						count_q <= cnt_ins;
					end
				end
				ST_DRAIN: begin
					if (slot_free) begin
						remain_q <= remain_q - dtk_pkg::cnt_t'(1);
						if (remain_q == dtk_pkg::cnt_t'(1)) begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_NONE: begin
					if (slot_free) begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && state_q == ST_DRAIN) begin
			out_q <= drain_item;
		end else if (slot_free && state_q == ST_NONE) begin
			out_q <= none_item;
		end
	end

	`DTK_NEVER(a_count_bound, count_q > dtk_pkg::cnt_t'(dtk_pkg::MAX_KEEP), "kept count above store size")
	`DTK_NEVER(a_drain_nonzero, (state_q == ST_DRAIN) && (remain_q == '0), "drain with nothing left")
	`DTK_ASSERT(a_frame_clear, frame_end |=> (count_q == '0), "store not emptied at frame end")

endmodule

`default_nettype wire
